// ===== sv/vlid_pkg.sv =====
// types, codes and operand helper shared by the instruction decoder modules
package vlid_pkg;

   localparam logic [7:0] StopByte = 8'h0F;
   localparam logic [4:0] StopOpcode = 5'h0F;

   localparam logic [1:0] KindNone = 2'd0;
   localparam logic [1:0] KindReg = 2'd1;
   localparam logic [1:0] KindImm = 2'd2;
   localparam logic [1:0] KindMem = 2'd3;

   localparam int WindowBytes = 7;
   localparam int ReqDataBits = 72;
   localparam int RspFieldBits = 108;
   localparam int RspDataBits = 112;

   typedef struct packed {
      logic [4:0]         regnum;
      logic signed [15:0] value;
      logic [25:0]        raw;
   } operand_type;

   typedef struct packed {
      logic [25:0]        packed_b;
      logic [25:0]        packed_a;
      logic signed [15:0] value_b;
      logic [4:0]         register_b;
      logic signed [15:0] value_a;
      logic [4:0]         register_a;
      logic [1:0]         kind_b;
      logic [1:0]         kind_a;
      logic [1:0]         operand_count;
      logic [4:0]         opcode;
      logic [2:0]         length_bytes;
   } decoded_type;

   // one operand from its first three bytes; the kind code equals its byte count
   function automatic operand_type read_operand(logic [1:0] kind, logic [7:0] b1,
                                                logic [7:0] b2, logic [7:0] b3);
      operand_type op;
      op = '0;
      case (kind)
         KindReg: begin
            op.regnum = b1[4:0];
            op.raw = {kind, 16'h0000, b1};
         end
         KindImm: begin
            op.value = {b1, b2};
            op.raw = {kind, 8'h00, b1, b2};
         end
         KindMem: begin
            op.value = {b1, b2};
            op.regnum = b3[4:0];
            op.raw = {kind, b1, b2, b3};
         end
         default: begin
            op = '0;
         end
      endcase
      return op;
   endfunction

endpackage

// ===== sv/vlid_decode.sv =====
// combinational decode of one fetched instruction window
module vlid_decode (
   input  logic [55:0]                 window,
   input  logic                        fault,
   output vlid_pkg::decoded_type       decoded
);

   logic [7:0] win_bytes [vlid_pkg::WindowBytes];
   logic [7:0] first;
   logic [4:0] opcode;
   logic [1:0] count;
   logic [1:0] kind_a;
   logic [1:0] kind_b;
   vlid_pkg::operand_type op_a;
   vlid_pkg::operand_type op_b;
   logic [7:0] a_b1;
   logic [7:0] a_b2;
   logic [7:0] a_b3;

   always_comb begin
      for (int k = 0; k < vlid_pkg::WindowBytes; k++) begin
         win_bytes[k] = window[55 - 8 * k -: 8];
      end
   end

   assign first = win_bytes[0];

   always_comb begin
      opcode = '0;
      count = '0;
      kind_a = vlid_pkg::KindNone;
      kind_b = vlid_pkg::KindNone;
      if (fault) begin
         opcode = '0;
      end else if (first == vlid_pkg::StopByte) begin
         opcode = vlid_pkg::StopOpcode;
      end else if (first[5:4] == 2'b00) begin
         count = 2'd1;
         opcode = first[4:0];
         kind_a = first[7:6];
      end else begin
         count = 2'd2;
         opcode = {1'b1, first[3:0]};
         kind_a = first[5:4];
         kind_b = first[7:6];
      end
   end

   // operand b starts right after the first byte, a follows b's bytes
   always_comb begin
      case (kind_b)
         vlid_pkg::KindReg: begin
            a_b1 = win_bytes[2];
            a_b2 = win_bytes[3];
            a_b3 = win_bytes[4];
         end
         vlid_pkg::KindImm: begin
            a_b1 = win_bytes[3];
            a_b2 = win_bytes[4];
            a_b3 = win_bytes[5];
         end
         vlid_pkg::KindMem: begin
            a_b1 = win_bytes[4];
            a_b2 = win_bytes[5];
            a_b3 = win_bytes[6];
         end
         default: begin
            a_b1 = win_bytes[1];
            a_b2 = win_bytes[2];
            a_b3 = win_bytes[3];
         end
      endcase
   end

   assign op_b = vlid_pkg::read_operand(kind_b, win_bytes[1], win_bytes[2], win_bytes[3]);
   assign op_a = vlid_pkg::read_operand(kind_a, a_b1, a_b2, a_b3);

   always_comb begin
      decoded.opcode = opcode;
      decoded.operand_count = count;
      decoded.kind_a = kind_a;
      decoded.kind_b = kind_b;
      decoded.register_a = op_a.regnum;
      decoded.value_a = op_a.value;
      decoded.packed_a = op_a.raw;
      decoded.register_b = op_b.regnum;
      decoded.value_b = op_b.value;
      decoded.packed_b = op_b.raw;
      decoded.length_bytes = 3'd1 + {1'b0, kind_b} + {1'b0, kind_a};
   end

endmodule

// ===== sv/variable_length_instruction_decoder.sv =====
// top level: input beat register, decode, result register
// an accepted beat is decoded from the input register and then captured in the result register
// throughput: one beat per cycle; both register stages advance together when not stalled
// req_tready falls only when both the input and result registers hold beats
// reset (synchronous, active high) clears both valid flags; payload is not reset
module variable_length_instruction_decoder #(
   parameter int MEMORY_BYTES = 16384
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // fetch_address[15:0], instruction_window[71:16]
   input  logic [vlid_pkg::ReqDataBits-1:0]   req_tdata,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // opcode[4:0], operand_count[6:5], kind_a[8:7], kind_b[10:9], register_a[15:11],
   // value_a[31:16], register_b[36:32], value_b[52:37], packed_a[78:53],
   // packed_b[104:79], length_bytes[107:105], zero fill[111:108]
   output logic [vlid_pkg::RspDataBits-1:0]   rsp_tdata,
   // segment_fault[0]
   output logic                               rsp_tuser
);

   localparam logic [16:0] MemLimit = 17'(MEMORY_BYTES);

   logic        in_valid_ff;
   logic        in_valid_in;
   logic [15:0] addr_ff;
   logic [55:0] window_ff;
   logic        out_valid_ff;
   logic        out_valid_in;
   vlid_pkg::decoded_type decoded_ff;
   vlid_pkg::decoded_type decoded_in;
   logic        fault_ff;
   logic        fault_in;
   logic        out_load;
   logic        in_load;

   assign out_load = !out_valid_ff || rsp_tready;
   assign in_load = !in_valid_ff || out_load;
   assign req_tready = in_load;

   assign fault_in = {1'b0, addr_ff} >= MemLimit;

   vlid_decode u_decode (
      .window  (window_ff),
      .fault   (fault_in),
      .decoded (decoded_in)
   );

   always_comb begin
      in_valid_in = in_valid_ff;
      out_valid_in = out_valid_ff;
      if (out_load) begin
         out_valid_in = in_valid_ff;
      end
      if (in_load) begin
         in_valid_in = req_tvalid;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         in_valid_ff <= in_valid_in;
         out_valid_ff <= out_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (in_load && req_tvalid) begin
         addr_ff <= req_tdata[15:0];
         window_ff <= req_tdata[71:16];
      end
      if (out_load && in_valid_ff) begin
         decoded_ff <= decoded_in;
         fault_ff <= fault_in;
      end
   end

   assign rsp_tvalid = out_valid_ff;
   assign rsp_tuser = fault_ff;
   assign rsp_tdata = {4'b0000, decoded_ff.length_bytes, decoded_ff.packed_b,
                       decoded_ff.packed_a, decoded_ff.value_b, decoded_ff.register_b,
                       decoded_ff.value_a, decoded_ff.register_a, decoded_ff.kind_b,
                       decoded_ff.kind_a, decoded_ff.operand_count, decoded_ff.opcode};

endmodule

// ===== tb/variable_length_instruction_decoder_test.sv =====
// testbench for the instruction decoder: directed table then random windows, checked per field
module variable_length_instruction_decoder_test;
   timeunit 1ns;
   timeprecision 1ps;

   localparam int MemoryBytes = 16384;
   localparam int RandomItems = 1350;

   typedef struct packed {
      logic [4:0]  opcode;
      logic [1:0]  operand_count;
      logic [1:0]  kind_a;
      logic [1:0]  kind_b;
      logic [4:0]  register_a;
      logic [15:0] value_a;
      logic [4:0]  register_b;
      logic [15:0] value_b;
      logic [25:0] packed_a;
      logic [25:0] packed_b;
      logic [2:0]  length_bytes;
      logic        segment_fault;
   } decode_type;

   typedef struct packed {
      logic [4:0]  regnum;
      logic [15:0] value;
      logic [25:0] raw;
   } operand_fields_type;

   typedef struct {
      logic [15:0] addr;
      logic [55:0] window;
      bit          typed;
      decode_type  want;
   } stimulus_row_type;

   typedef enum int {FlowFree, FlowHalf, FlowChoked} flow_mode_type;

   logic                             clock = 1'b0;
   logic                             reset = 1'b1;
   logic                             req_tvalid = 1'b0;
   logic                             req_tready;
   logic [vlid_pkg::ReqDataBits-1:0] req_tdata = '0;
   logic                             rsp_tvalid;
   logic                             rsp_tready = 1'b0;
   logic [vlid_pkg::RspDataBits-1:0] rsp_tdata;
   logic                             rsp_tuser;

   decode_type       pending_decodes[$];
   stimulus_row_type directed_rows[$];
   int               error_count = 0;
   int               burst_left = 0;
   int               flow_left = 0;
   flow_mode_type    flow_mode = FlowFree;

   variable_length_instruction_decoder #(
      .MEMORY_BYTES(MemoryBytes)
   ) dut (
      .clock(clock),
      .reset(reset),
      .req_tvalid(req_tvalid),
      .req_tready(req_tready),
      .req_tdata(req_tdata),
      .rsp_tvalid(rsp_tvalid),
      .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata),
      .rsp_tuser(rsp_tuser)
   );

   always #5 clock = ~clock;

   // operand bytes start at pos; the kind code is also its byte count
   function automatic operand_fields_type operand_at(logic [1:0] kind, logic [55:0] window,
                                                     int pos);
      operand_fields_type f;
      logic [23:0]        bytes;
      logic [55:0]        shifted;
      f = '0;
      bytes = '0;
      for (int i = 0; i < int'(kind); i++) begin
         shifted = window >> (8 * (6 - (pos + i)));
         bytes = {bytes[15:0], shifted[7:0]};
      end
      if (kind != vlid_pkg::KindNone) begin
         f.raw = {kind, bytes};
      end
      if (kind == vlid_pkg::KindImm) begin
         f.value = bytes[15:0];
      end
      if (kind == vlid_pkg::KindMem) begin
         f.value = bytes[23:8];
      end
      if (kind == vlid_pkg::KindReg || kind == vlid_pkg::KindMem) begin
         f.regnum = bytes[4:0];
      end
      return f;
   endfunction

   function automatic decode_type predict_decode(logic [15:0] addr, logic [55:0] window);
      decode_type         d;
      operand_fields_type op_a;
      operand_fields_type op_b;
      logic [7:0]         first;
      int                 pos;
      d = '0;
      first = window[55:48];
      pos = 1;
      if (addr >= MemoryBytes) begin
         d.segment_fault = 1'b1;
         d.length_bytes = 3'd1;
         return d;
      end
      if (first == vlid_pkg::StopByte) begin
         d.opcode = vlid_pkg::StopOpcode;
      end else if (first[5:4] == vlid_pkg::KindNone) begin
         d.operand_count = 2'd1;
         d.opcode = first[4:0];
         d.kind_a = first[7:6];
      end else begin
         d.operand_count = 2'd2;
         d.opcode = {1'b1, first[3:0]};
         d.kind_a = first[5:4];
         d.kind_b = first[7:6];
      end
      // operand b bytes come first
      if (d.operand_count == 2'd2) begin
         op_b = operand_at(d.kind_b, window, pos);
         pos = pos + int'(d.kind_b);
         d.register_b = op_b.regnum;
         d.value_b = op_b.value;
         d.packed_b = op_b.raw;
      end
      if (d.operand_count != 2'd0) begin
         op_a = operand_at(d.kind_a, window, pos);
         pos = pos + int'(d.kind_a);
         d.register_a = op_a.regnum;
         d.value_a = op_a.value;
         d.packed_a = op_a.raw;
      end
      d.length_bytes = pos[2:0];
      return d;
   endfunction

   function automatic decode_type typed_decode(logic [4:0] opcode, logic [1:0] count,
                                               logic [2:0] length, logic fault);
      decode_type d;
      d = '0;
      d.opcode = opcode;
      d.operand_count = count;
      d.length_bytes = length;
      d.segment_fault = fault;
      return d;
   endfunction

   task automatic add_row(logic [15:0] addr, logic [55:0] window, bit typed,
                          decode_type want);
      stimulus_row_type row;
      row.addr = addr;
      row.window = window;
      row.typed = typed;
      row.want = want;
      directed_rows.push_back(row);
   endtask

   // called at a falling edge, returns at the falling edge after the beat is taken
   task automatic send_instruction(logic [15:0] addr, logic [55:0] window, decode_type want);
      int gap;
      if (burst_left == 0) begin
         gap = $urandom_range(1, 6);
         req_tvalid <= 1'b0;
         repeat (gap) @(negedge clock);
         burst_left = $urandom_range(1, 40);
      end
      req_tvalid <= 1'b1;
      req_tdata <= {window, addr};
      do @(posedge clock); while (!req_tready);
      pending_decodes.push_back(want);
      burst_left--;
      @(negedge clock);
   endtask

   task automatic check_field(string name, logic [31:0] want, logic [31:0] got);
      if (want !== got) begin
         $error("%s expected %0h actual %0h", name, want, got);
         error_count++;
      end
   endtask

   // receiver stalls in stretches: free running, half rate, mostly stalled
   always @(negedge clock) begin
      if (flow_left == 0) begin
         flow_mode = flow_mode_type'($urandom_range(0, 2));
         flow_left = $urandom_range(8, 80);
      end
      flow_left--;
      case (flow_mode)
         FlowFree: begin
            rsp_tready <= 1'b1;
         end
         FlowHalf: begin
            rsp_tready <= 1'($urandom_range(0, 1));
         end
         default: begin
            rsp_tready <= ($urandom_range(0, 3) == 0);
         end
      endcase
   end

   always @(posedge clock) begin
      decode_type want;
      if (!reset && rsp_tvalid && rsp_tready) begin
         if (pending_decodes.size() == 0) begin
            $error("result beat with no instruction outstanding");
            error_count++;
         end else begin
            want = pending_decodes.pop_front();
            check_field("opcode", 32'(want.opcode), 32'(rsp_tdata[4:0]));
            check_field("operand_count", 32'(want.operand_count), 32'(rsp_tdata[6:5]));
            check_field("kind_a", 32'(want.kind_a), 32'(rsp_tdata[8:7]));
            check_field("kind_b", 32'(want.kind_b), 32'(rsp_tdata[10:9]));
            check_field("register_a", 32'(want.register_a), 32'(rsp_tdata[15:11]));
            check_field("value_a", 32'(want.value_a), 32'(rsp_tdata[31:16]));
            check_field("register_b", 32'(want.register_b), 32'(rsp_tdata[36:32]));
            check_field("value_b", 32'(want.value_b), 32'(rsp_tdata[52:37]));
            check_field("packed_a", 32'(want.packed_a), 32'(rsp_tdata[78:53]));
            check_field("packed_b", 32'(want.packed_b), 32'(rsp_tdata[104:79]));
            check_field("length_bytes", 32'(want.length_bytes), 32'(rsp_tdata[107:105]));
            check_field("segment_fault", 32'(want.segment_fault), 32'(rsp_tuser));
         end
      end
   end

   initial begin
      #5_000_000;
      $display("variable_length_instruction_decoder_test: FAIL");
      $finish;
   end

   initial begin
      logic [15:0] addr;
      logic [55:0] window;
      logic [7:0]  first;
      int          drain;

      // stop byte, all-zero window, address faults, last legal address
      add_row(16'h0000, {vlid_pkg::StopByte, 48'hFFFF_FFFF_FFFF}, 1'b1,
              typed_decode(vlid_pkg::StopOpcode, 2'd0, 3'd1, 1'b0));
      add_row(16'h0000, 56'h0, 1'b1, typed_decode(5'h00, 2'd1, 3'd1, 1'b0));
      add_row(16'(MemoryBytes), 56'hFF_FFFF_FFFF_FFFF, 1'b1,
              typed_decode(5'h00, 2'd0, 3'd1, 1'b1));
      add_row(16'hFFFF, {vlid_pkg::StopByte, 48'h1234_5678_9ABC}, 1'b1,
              typed_decode(5'h00, 2'd0, 3'd1, 1'b1));
      add_row(16'(MemoryBytes - 1), 56'hFF_FFFF_FFFF_FFFF, 1'b0, '0);
      // one operand, opcode nibble matching the stop code but not a stop
      add_row(16'h0001, 56'h4F_FF00_0000_0000, 1'b0, '0);
      add_row(16'h0002, 56'h8F_8000_AAAA_AAAA, 1'b0, '0);
      add_row(16'h0003, 56'hCF_7FFF_E155_5555, 1'b0, '0);
      // immediate extremes
      add_row(16'h2000, 56'h81_7FFF_0000_0000, 1'b0, '0);
      add_row(16'h0100, 56'h82_8000_FFFF_FFFF, 1'b0, '0);
      // every two-operand kind pairing
      for (int ka = vlid_pkg::KindReg; ka <= vlid_pkg::KindMem; ka++) begin
         for (int kb = vlid_pkg::KindNone; kb <= vlid_pkg::KindMem; kb++) begin
            first = {2'(kb), 2'(ka), 4'(ka * 4 + kb)};
            add_row(16'(ka * 4 + kb), {first, 16'hA5C3, 16'h5A3C, 16'h8001}, 1'b0, '0);
         end
      end

      repeat (5) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      foreach (directed_rows[i]) begin
         send_instruction(directed_rows[i].addr, directed_rows[i].window,
                          directed_rows[i].typed ? directed_rows[i].want
                             : predict_decode(directed_rows[i].addr, directed_rows[i].window));
      end

      for (int n = 0; n < RandomItems; n++) begin
         if ($urandom_range(0, 99) < 12) begin
            addr = 16'($urandom_range(MemoryBytes, 65535));
         end else begin
            addr = 16'($urandom_range(0, MemoryBytes - 1));
         end
         window = {24'($urandom), 32'($urandom)};
         if ($urandom_range(0, 19) == 0) begin
            window[55:48] = vlid_pkg::StopByte;
         end
         send_instruction(addr, window, predict_decode(addr, window));
      end
      req_tvalid <= 1'b0;

      drain = 0;
      while (pending_decodes.size() != 0 && drain < 100_000) begin
         @(posedge clock);
         drain++;
      end
      repeat (8) @(posedge clock);

      if (error_count == 0 && pending_decodes.size() == 0) begin
         $display("variable_length_instruction_decoder_test: PASS");
      end else begin
         $display("variable_length_instruction_decoder_test: FAIL");
      end
      $finish;
   end

endmodule
